// ----- hw/rtl/bcx_pkg.sv -----
// Package for the bytecode execute block: sizes, opcodes, fault codes and
// the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package bcx_pkg;

  localparam int MemDepthDef   = 256;
  localparam int StackDepthDef = 1024;
  localparam int PcWidthDef    = 16;

  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_STORE = 4'd1;
  localparam logic [3:0] OP_CALL  = 4'd2;
  localparam logic [3:0] OP_STACK = 4'd3;
  localparam logic [3:0] OP_ADD   = 4'd4;
  localparam logic [3:0] OP_SUB   = 4'd5;
  localparam logic [3:0] OP_MUL   = 4'd6;
  localparam logic [3:0] OP_DIV   = 4'd7;
  localparam logic [3:0] OP_MOD   = 4'd8;
  localparam logic [3:0] OP_CMP   = 4'd9;
  localparam logic [3:0] OP_JUMP  = 4'd10;
  localparam logic [3:0] OP_INC   = 4'd11;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_OVER  = 2'd1;
  localparam logic [1:0] FAULT_UNDER = 2'd2;
  localparam logic [1:0] FAULT_DIV0  = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch incoming item
    logic step;      // execute latched item (first execute cycle)
    logic div_run;   // run one divider step
    logic mul_run;   // run one multiplier partial product
    logic commit;    // write back and form the result
  } bcx_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_div;    // item needs the divider
    logic is_mul;    // item needs the multiplier
    logic div_done;
    logic mul_done;
  } bcx_stat_t;

endpackage

// ----- hw/rtl/bcx_ctrl.sv -----
// Controller for the bytecode execute block: sequences capture, execute,
// multi-cycle arithmetic, commit and the output handshake.
// Depends on bcx_pkg.
`timescale 1ns / 1ps
module bcx_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_stall,
  output logic               out_valid,
  input  bcx_pkg::bcx_stat_t stat,
  output bcx_pkg::bcx_cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_DIV, S_MUL, S_FIN} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Accept when idle and no result is waiting, or the waiting one is taken now
  assign in_stall  = !(state_r == S_IDLE && (!out_valid_r || !out_stall));
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        cmd.step = 1'b1;
        if (stat.is_div) state_nxt = S_DIV;
        else if (stat.is_mul) state_nxt = S_MUL;
        else state_nxt = S_FIN;
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (stat.div_done) state_nxt = S_FIN;
      end
      S_MUL: begin
        cmd.mul_run = 1'b1;
        if (stat.mul_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        // Output is free here: nothing new was accepted while a result waited
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/bcx_dpath.sv -----
// Datapath of the bytecode execute block: registers, flags, code and stack
// pointers, data memory with valid bits, stack memory, radix-2 divider and
// a 4x16-bit partial-product multiplier. Depends on bcx_pkg.
`timescale 1ns / 1ps
module bcx_dpath #(
  parameter int MEM_DEPTH   = bcx_pkg::MemDepthDef,
  parameter int STACK_DEPTH = bcx_pkg::StackDepthDef,
  parameter int PC_WIDTH    = bcx_pkg::PcWidthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bcx_pkg::bcx_cmd_t  cmd,
  output bcx_pkg::bcx_stat_t stat,
  input  logic               in_mode,
  input  logic [7:0]         in_opcode_byte,
  input  logic [7:0]         in_operand_byte,
  input  logic [63:0]        in_immediate,
  output logic [15:0]        out_next_pc,
  output logic               out_call_request,
  output logic [7:0]         out_call_symbol,
  output logic [1:0]         out_fault,
  output logic               out_dest_valid,
  output logic [1:0]         out_dest_reg,
  output logic [63:0]        out_dest_value
);

  localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = SAW + 1;

  // Latched item
  logic        mode_r;
  logic [7:0]  op_r, arg_r;
  logic [63:0] imm_r;

  // Architectural state
  logic [63:0]         gpr_r [4];
  logic                eq_r, lt_r, gt_r;
  logic [PC_WIDTH-1:0] pc_r;
  logic [SPW-1:0]      sp_r;
  logic [63:0]         dmem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] dvalid_r;
  logic [63:0]         smem [STACK_DEPTH];

  // Execute-stage registers
  logic [63:0] a_r, b_r, mrd_r, srd_r;
  logic        mvalid_rd_r;

  // Divider / multiplier state
  logic [6:0]  dcnt_r;
  logic [63:0] prod_r;
  logic [1:0]  mcnt_r;
  logic        mdone_r;

  logic [3:0]     opc;
  logic [1:0]     ra, rb;
  logic [MAW-1:0] midx;
  assign opc  = op_r[3:0];
  assign ra   = op_r[5:4];
  assign rb   = op_r[7:6];
  assign midx = MAW'(arg_r);

  assign stat.is_div   = !mode_r && (opc == bcx_pkg::OP_DIV || opc == bcx_pkg::OP_MOD);
  assign stat.is_mul   = !mode_r && (opc == bcx_pkg::OP_MUL);
  assign stat.div_done = (dcnt_r == 7'd63);
  assign stat.mul_done = mdone_r;

  // Capture item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      op_r   <= in_opcode_byte;
      arg_r  <= in_operand_byte;
      imm_r  <= in_immediate;
    end
  end

  // Read operands, memory and stack top
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      a_r         <= gpr_r[ra];
      b_r         <= gpr_r[rb];
      mrd_r       <= dmem[midx];
      mvalid_rd_r <= dvalid_r[midx];
      srd_r       <= smem[SAW'(sp_r - SPW'(1))];
    end
  end

  // Divider step counter: 64 steps
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      dcnt_r <= '0;
    end else if (cmd.div_run) begin
      dcnt_r <= dcnt_r + 7'd1;
    end
  end

  // Divider working registers: one restoring step per cycle, MSB first
  logic [63:0] dq_r, dr_r;
  logic [64:0] dtrial;
  assign dtrial = {dr_r, dq_r[63]} - {1'b0, b_r};
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      dq_r <= gpr_r[ra];
      dr_r <= '0;
    end else if (cmd.div_run) begin
      if (!dtrial[64]) begin
        dr_r <= dtrial[63:0];
        dq_r <= {dq_r[62:0], 1'b1};
      end else begin
        dr_r <= {dr_r[62:0], dq_r[63]};
        dq_r <= {dq_r[62:0], 1'b0};
      end
    end
  end

  // Multiplier: low 64 bits from four 64x16 partial products
  logic [15:0] bsl;
  logic [79:0] pp;
  assign bsl = b_r[16*mcnt_r +: 16];
  assign pp  = a_r * bsl;
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      prod_r  <= '0;
      mcnt_r  <= '0;
      mdone_r <= 1'b0;
    end else if (cmd.mul_run && !mdone_r) begin
      prod_r <= prod_r + (pp[63:0] << (16 * mcnt_r));
      mcnt_r <= mcnt_r + 2'd1;
      if (mcnt_r == 2'd3) mdone_r <= 1'b1;
    end
  end

  // Form result
  logic [63:0]         memw;
  logic                push_ok, pop_ok, jmp;
  logic                dv;
  logic [1:0]          dr, fault;
  logic [63:0]         dval;
  logic [3:0]          len;
  logic [PC_WIDTH-1:0] pc_nxt;

  assign memw    = mvalid_rd_r ? mrd_r : 64'd0;
  assign push_ok = (sp_r < SPW'(STACK_DEPTH));
  assign pop_ok  = (sp_r != '0);

  always_comb begin
    dv = 1'b0; dr = 2'd0; dval = 64'd0; fault = bcx_pkg::FAULT_NONE;
    len = 4'd1; jmp = 1'b0;
    case (opc)
      bcx_pkg::OP_LOAD: begin
        dv = 1'b1; dr = ra; len = 4'd2;
        case (rb)
          2'd0:    dval = 64'(midx);
          2'd1:    dval = memw;
          2'd2:    dval = 64'(arg_r);
          default: begin dval = imm_r; len = 4'd9; end
        endcase
      end
      bcx_pkg::OP_STORE: len = 4'd2;
      bcx_pkg::OP_CALL:  len = 4'd2;
      bcx_pkg::OP_STACK: begin
        if (op_r[6]) begin
          if (!pop_ok) fault = bcx_pkg::FAULT_UNDER;
          else begin dv = 1'b1; dr = ra; dval = srd_r; end
        end else if (!push_ok) fault = bcx_pkg::FAULT_OVER;
      end
      bcx_pkg::OP_ADD: begin dv = 1'b1; dval = a_r + b_r; end
      bcx_pkg::OP_SUB: begin dv = 1'b1; dval = a_r - b_r; end
      bcx_pkg::OP_MUL: begin dv = 1'b1; dval = prod_r; end
      bcx_pkg::OP_DIV: begin
        dv = 1'b1;
        if (b_r == 64'd0) begin dval = '1; fault = bcx_pkg::FAULT_DIV0; end
        else dval = dq_r;
      end
      bcx_pkg::OP_MOD: begin
        dv = 1'b1;
        if (b_r == 64'd0) begin dval = a_r; fault = bcx_pkg::FAULT_DIV0; end
        else dval = dr_r;
      end
      bcx_pkg::OP_JUMP: begin
        len = 4'd9;
        jmp = !op_r[7] || (op_r[6] && gt_r) || (op_r[5] && lt_r) || (op_r[4] && eq_r);
      end
      bcx_pkg::OP_INC: begin
        dv = 1'b1; dr = ra;
        dval = op_r[7] ? a_r - 64'd1 : a_r + 64'd1;
      end
      default: ;
    endcase
    pc_nxt = jmp ? imm_r[PC_WIDTH-1:0] : pc_r + PC_WIDTH'(len);
  end

  // Commit registers, flags, pointers and memory valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) gpr_r[i] <= '0;
      eq_r <= 1'b0; lt_r <= 1'b0; gt_r <= 1'b0;
      pc_r <= '0; sp_r <= '0; dvalid_r <= '0;
    end else if (cmd.commit) begin
      if (mode_r) begin
        dvalid_r[midx] <= 1'b1;
      end else begin
        if (dv) gpr_r[dr] <= dval;
        if (opc == bcx_pkg::OP_STORE) dvalid_r[midx] <= 1'b1;
        if (opc == bcx_pkg::OP_CMP) begin
          eq_r <= (a_r == b_r); lt_r <= (a_r < b_r); gt_r <= (a_r > b_r);
        end
        if (opc == bcx_pkg::OP_STACK) begin
          if (op_r[6] && pop_ok) sp_r <= sp_r - SPW'(1);
          else if (!op_r[6] && push_ok) sp_r <= sp_r + SPW'(1);
        end
        pc_r <= pc_nxt;
      end
    end
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (mode_r) dmem[midx] <= imm_r;
      else if (opc == bcx_pkg::OP_STORE) dmem[midx] <= gpr_r[arg_r[5:4]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !mode_r && opc == bcx_pkg::OP_STACK && !op_r[6] && push_ok)
      smem[SAW'(sp_r)] <= a_r;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (mode_r) begin
        out_next_pc      <= 16'(pc_r);
        out_call_request <= 1'b0;
        out_call_symbol  <= 8'd0;
        out_fault        <= bcx_pkg::FAULT_NONE;
        out_dest_valid   <= 1'b0;
        out_dest_reg     <= 2'd0;
        out_dest_value   <= 64'd0;
      end else begin
        out_next_pc      <= 16'(pc_nxt);
        out_call_request <= (opc == bcx_pkg::OP_CALL);
        out_call_symbol  <= (opc == bcx_pkg::OP_CALL) ? arg_r : 8'd0;
        out_fault        <= fault;
        out_dest_valid   <= dv;
        out_dest_reg     <= dv ? dr : 2'd0;
        out_dest_value   <= dv ? dval : 64'd0;
      end
    end
  end

endmodule

// ----- hw/rtl/bytecode_cpu_execute_top.sv -----
// Top level of the bytecode execute block: controller plus datapath.
// Depends on bcx_pkg, bcx_ctrl and bcx_dpath.
//
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_valid / in_stall | mode, opcode_byte, operand_byte, immediate
//  out_    | output    | out_valid/out_stall | next_pc .. dest_value
//
// A result is registered in the commit state after its item is captured and
// executed; a multiply first runs four 64x16 partial products and a done
// check, divide or modulo 64 radix-2 divider steps. The next item is taken
// only once the block is idle again, so items never overlap.
// Reset clears registers, flags, pointers and memory valid bits.
// A stalled result holds in the output register; no new item enters meanwhile.
`timescale 1ns / 1ps
module bytecode_cpu_execute_top #(
  parameter int MEM_DEPTH   = bcx_pkg::MemDepthDef,
  parameter int STACK_DEPTH = bcx_pkg::StackDepthDef,
  parameter int PC_WIDTH    = bcx_pkg::PcWidthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_opcode_byte,
  input  logic [7:0]  in_operand_byte,
  input  logic [63:0] in_immediate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_next_pc,
  output logic        out_call_request,
  output logic [7:0]  out_call_symbol,
  output logic [1:0]  out_fault,
  output logic        out_dest_valid,
  output logic [1:0]  out_dest_reg,
  output logic [63:0] out_dest_value
);

  bcx_pkg::bcx_cmd_t  cmd;
  bcx_pkg::bcx_stat_t stat;

  bcx_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_stall, .out_valid,
    .stat, .cmd
  );

  bcx_dpath #(
    .MEM_DEPTH(MEM_DEPTH), .STACK_DEPTH(STACK_DEPTH), .PC_WIDTH(PC_WIDTH)
  ) u_dpath (
    .clk, .rst_n, .cmd, .stat,
    .in_mode, .in_opcode_byte, .in_operand_byte, .in_immediate,
    .out_next_pc, .out_call_request, .out_call_symbol, .out_fault,
    .out_dest_valid, .out_dest_reg, .out_dest_value
  );

endmodule

// ----- hw/rtl/bcx_checker.sv -----
// Port-level checker for the bytecode execute block, bound to the top level.
// Depends on bytecode_cpu_execute_top.
`timescale 1ns / 1ps
module bcx_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_fault,
  input logic        out_dest_valid,
  input logic [1:0]  out_dest_reg,
  input logic [63:0] out_dest_value,
  input logic        out_call_request
);

  // A result does not come out in the cycle after an item is accepted
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result too early");

  // No item is accepted while a stalled result waits
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("accepted over stalled result");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_dest_value)))
    else $error("stalled result changed");

  // No register written means zero register fields
  a_dest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_dest_valid) |-> (out_dest_reg == 2'd0 && out_dest_value == 64'd0))
    else $error("dest fields not cleared");

  // Calls carry no fault and write no register
  a_call: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_call_request) |-> (out_fault == 2'd0 && !out_dest_valid))
    else $error("call with fault or write");

endmodule

bind bytecode_cpu_execute_top bcx_port_props u_bcx_port_props (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_fault,
  .out_dest_valid, .out_dest_reg, .out_dest_value, .out_call_request
);
